// ===== rtl/core/scanline_span_coverage_accumulator_macros.svh =====
// Assertion macros used by the scanline span coverage accumulator back end.
`ifndef SCANLINE_SPAN_COVERAGE_ACCUMULATOR_MACROS_SVH
`define SCANLINE_SPAN_COVERAGE_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SCSA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scsa assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SCSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scsa assertion failed");

`endif

// ===== rtl/core/scsa_pkg.sv =====
// Shared types and constants of the scanline span coverage accumulator.
`timescale 1ns / 1ps
`default_nettype none
package scsa_pkg;

   localparam int ROW_WIDTH_DEF   = 1024;
   localparam int X_FRAC_BITS_DEF = 8;

   localparam int X_W        = 19;
   localparam int IDX_W      = 10;
   localparam int PIX_W      = 8;
   localparam int ROW_LEN_W  = 11;
   localparam int WEIGHT_W   = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REQ_DATA_W = 48;

   localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST  = 11'd1024;
   localparam logic [WEIGHT_W-1:0]  FULL_WEIGHT_RST = 8'd51;

   localparam logic CMD_SPAN = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic REG_ROW_LENGTH  = 1'b0;
   localparam logic REG_FULL_WEIGHT = 1'b1;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic                    is_read;
      logic signed [X_W-1:0]   start_x;
      logic signed [X_W-1:0]   end_x;
      logic [IDX_W-1:0]        pixel_index;
   } item_type;

endpackage
`default_nettype wire

// ===== rtl/core/scsa_front.sv =====
// Front end: accepts commands, drops spans that are reversed or miss the row, forwards the rest.
`timescale 1ns / 1ps
`default_nettype none
module scsa_front #(
   parameter int ROW_WIDTH   = scsa_pkg::ROW_WIDTH_DEF,
   parameter int X_FRAC_BITS = scsa_pkg::X_FRAC_BITS_DEF,
   localparam int LW = $clog2(ROW_WIDTH + 1)
) (
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [scsa_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                              req_tuser,
   input  wire logic [LW-1:0]                     eff_len,
   input  wire logic                              clear_busy,
   input  wire logic                              q_ready,
   output logic                                   q_valid,
   output scsa_pkg::item_type                     q_item
);

   localparam int XW = (LW + X_FRAC_BITS + 2 > 20) ? LW + X_FRAC_BITS + 2 : 20;

   logic signed [XW-1:0] s_x;
   logic signed [XW-1:0] e_x;
   logic signed [XW-1:0] lim_x;
   logic                 drop;

   always_comb begin
      q_item.is_read     = (req_tuser == scsa_pkg::CMD_READ);
      q_item.start_x     = $signed(req_tdata[scsa_pkg::X_W-1:0]);
      q_item.end_x       = $signed(req_tdata[2*scsa_pkg::X_W-1:scsa_pkg::X_W]);
      q_item.pixel_index = req_tdata[2*scsa_pkg::X_W+scsa_pkg::IDX_W-1:2*scsa_pkg::X_W];
   end

   assign s_x   = XW'(q_item.start_x);
   assign e_x   = XW'(q_item.end_x);
   assign lim_x = $signed(XW'(eff_len) << X_FRAC_BITS);

   // A span is dropped when the row is empty, it is reversed, or it misses the row.
   assign drop = !q_item.is_read &&
                 ((eff_len == '0) || (e_x < s_x) || (s_x >= lim_x) || (e_x < $signed(XW'(0))));

   assign req_tready = q_ready && !clear_busy;
   assign q_valid    = req_tvalid && req_tready && !drop;

endmodule
`default_nettype wire

// ===== rtl/core/scsa_queue.sv =====
// Short queue that decouples the front end from the row walker.
`timescale 1ns / 1ps
`default_nettype none
module scsa_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire scsa_pkg::item_type  in_item,
   output logic                     out_valid,
   input  wire logic                out_pop,
   output scsa_pkg::item_type       out_item
);

   localparam int PW = (scsa_pkg::QUEUE_DEPTH > 1) ? $clog2(scsa_pkg::QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(scsa_pkg::QUEUE_DEPTH + 1);

   scsa_pkg::item_type entry_ff [scsa_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          push, pop;

   assign in_ready  = (count_ff != NW'(scsa_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(scsa_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(scsa_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/scsa_back.sv =====
// Back end: row store, clearing pass, column walker and read-and-clear path.
`timescale 1ns / 1ps
`default_nettype none
`include "scanline_span_coverage_accumulator_macros.svh"
module scsa_back #(
   parameter int ROW_WIDTH   = scsa_pkg::ROW_WIDTH_DEF,
   parameter int X_FRAC_BITS = scsa_pkg::X_FRAC_BITS_DEF,
   localparam int LW = $clog2(ROW_WIDTH + 1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [LW-1:0]                    eff_len,
   input  wire logic [scsa_pkg::WEIGHT_W-1:0]    full_weight,
   input  wire logic                             q_valid,
   input  wire scsa_pkg::item_type               q_item,
   output logic                                  q_pop,
   output logic                                  clear_busy,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [scsa_pkg::PIX_W-1:0]            rsp_tdata
);

   localparam int CW = $clog2(ROW_WIDTH);
   localparam int XW = (LW + X_FRAC_BITS + 2 > 20) ? LW + X_FRAC_BITS + 2 : 20;
   localparam int IW = (CW + 1 > scsa_pkg::IDX_W) ? CW + 1 : scsa_pkg::IDX_W;
   localparam int PW = scsa_pkg::PIX_W;
   localparam logic signed [XW-1:0] PIX_STEP = XW'(1) << X_FRAC_BITS;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_LOAD  = 4'b0100,
      ST_WALK  = 4'b1000
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic [CW-1:0]      clr_cnt_ff, clr_cnt_in;
   scsa_pkg::item_type item_ff, item_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [CW-1:0]      first_ff, first_in;
   logic [CW-1:0]      last_ff, last_in;

   logic               s2_valid_ff, s2_valid_in;
   logic               s2_read_ff, s2_hit_ff, s2_partial_ff;
   logic [CW-1:0]      s2_col_ff;
   logic [PW-1:0]      s2_amt_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]      rsp_data_ff, rsp_data_in;

   logic [PW-1:0]      mem [ROW_WIDTH];
   logic [PW-1:0]      rdata_ff;

   logic               issue;
   logic               issue_read;
   logic [CW-1:0]      rd_addr;
   logic               read_hit;

   logic               we;
   logic [CW-1:0]      wr_addr;
   logic [PW-1:0]      wr_data;

   logic signed [XW-1:0] s_x, e_x, len_x, e_col;
   logic signed [XW-1:0] lo_x, hi_x, cs_x, ce_x, cov_x;
   logic [X_FRAC_BITS+8:0] prod;
   logic [PW-1:0]          amt;
   logic [PW:0]            sum;

   assign s_x   = XW'(item_ff.start_x);
   assign e_x   = XW'(item_ff.end_x);
   assign len_x = $signed(XW'(eff_len));
   assign e_col = e_x >>> X_FRAC_BITS;

   // Coverage of the current column and the amount it adds.
   assign lo_x  = $signed(XW'(col_ff) << X_FRAC_BITS);
   assign hi_x  = lo_x + PIX_STEP;
   assign cs_x  = (s_x < lo_x) ? lo_x : ((s_x > hi_x) ? hi_x : s_x);
   assign ce_x  = (e_x < lo_x) ? lo_x : ((e_x > hi_x) ? hi_x : e_x);
   assign cov_x = ce_x - cs_x;
   assign prod  = {8'b0, cov_x[X_FRAC_BITS:0]} *
                  {{(X_FRAC_BITS + 1){1'b0}}, full_weight};
   assign amt   = prod[X_FRAC_BITS+7:X_FRAC_BITS];

   assign read_hit = (IW'(item_ff.pixel_index) < IW'(ROW_WIDTH));

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      item_in    = item_ff;
      col_in     = col_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      q_pop      = 1'b0;
      issue      = 1'b0;
      issue_read = 1'b0;
      rd_addr    = col_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CW'(ROW_WIDTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // Wait out a pending write so the next item reads fresh data.
            if (q_valid && !s2_valid_ff) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (item_ff.is_read) begin
               rd_addr = CW'(item_ff.pixel_index);
               if (!rsp_valid_ff || rsp_tready) begin
                  issue      = 1'b1;
                  issue_read = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               col_in   = (s_x < $signed(XW'(0))) ? '0 : CW'(s_x >>> X_FRAC_BITS);
               first_in = col_in;
               last_in  = (e_col >= len_x) ? CW'(len_x - XW'(1)) : CW'(e_col);
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            issue = 1'b1;
            if (col_ff == last_ff) begin
               state_in = ST_IDLE;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign s2_valid_in = issue;
   assign clear_busy  = (state_ff == ST_CLEAR);

   // Second stage: read data is back, write the updated pixel.
   assign sum = {1'b0, rdata_ff} + {1'b0, s2_amt_ff};

   always_comb begin
      we      = 1'b0;
      wr_addr = s2_col_ff;
      wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         we      = 1'b1;
         wr_addr = clr_cnt_ff;
      end else if (s2_valid_ff) begin
         if (s2_read_ff) begin
            we = s2_hit_ff;
         end else begin
            we      = 1'b1;
            wr_data = (s2_partial_ff && sum[PW]) ? {PW{1'b1}} : sum[PW-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (s2_valid_ff && s2_read_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = s2_hit_ff ? rdata_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      col_ff        <= col_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      rsp_data_ff   <= rsp_data_in;
      s2_read_ff    <= issue_read;
      s2_hit_ff     <= read_hit;
      s2_col_ff     <= rd_addr;
      s2_amt_ff     <= amt;
      s2_partial_ff <= (col_ff == first_ff) || (col_ff == last_ff);
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   `SCSA_ASSERT_IMPL(a_no_pop_in_clear, clock, reset, state_ff == ST_CLEAR, !q_pop)
   `SCSA_ASSERT_IMPL(a_pop_after_write, clock, reset, q_pop, !s2_valid_ff)
   `SCSA_ASSERT_IMPL(a_rsp_slot_free, clock, reset, s2_valid_ff && s2_read_ff, !rsp_valid_ff)
   `SCSA_ASSERT_IMPL(a_walk_in_span, clock, reset, state_ff == ST_WALK, col_ff <= last_ff)
   `SCSA_ASSERT_NEXT(a_walk_issues, clock, reset, state_ff == ST_LOAD && !item_ff.is_read,
                     state_ff == ST_WALK)

endmodule
`default_nettype wire

// ===== rtl/core/scanline_span_coverage_accumulator.sv =====
// Top level of the scanline span coverage accumulator: registers and wiring.
//
//   Channel  Direction  Carries
//   req_     in         span command or pixel read (tuser selects), 48-bit tdata
//   rsp_     out        pixel value of a read, 8-bit tdata
//   csr_     in         APB-style register port: row_length at 0x0, full_weight at 0x4
//
// A span in the row walker is popped, then its clipped column range is worked out, then
// each of its columns is issued to the row store in turn, and the last write lands in the
// second stage. A read is popped and issued to the row store once the result slot is free.
// After reset a clearing pass writes zero to all ROW_WIDTH pixels, one per cycle;
// req_tready stays low during the pass. Register writes are taken at any time.
// Spans that miss the row are dropped at the front and only occupy a transfer.
// The front keeps accepting into a two-entry queue while the walker is busy. A result
// waiting on rsp_tready holds the walker at the next read, and the front then stalls
// once the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module scanline_span_coverage_accumulator #(
   parameter int ROW_WIDTH   = scsa_pkg::ROW_WIDTH_DEF,
   parameter int X_FRAC_BITS = scsa_pkg::X_FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Command stream.
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // tdata: start_x[18:0], end_x[37:19], pixel_index[47:38].
   input  wire logic [scsa_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: cmd (0 accumulate span, 1 read and clear pixel).
   input  wire logic                               req_tuser,
   // Result stream.
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // tdata: pixel_value[7:0].
   output logic [scsa_pkg::PIX_W-1:0]              rsp_tdata,
   // Register port.
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [scsa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [scsa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [scsa_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                    csr_pready
);

   localparam int LW    = $clog2(ROW_WIDTH + 1);
   localparam int CMP_W = (LW > scsa_pkg::ROW_LEN_W) ? LW : scsa_pkg::ROW_LEN_W;

   logic [scsa_pkg::ROW_LEN_W-1:0] row_length_ff, row_length_in;
   logic [scsa_pkg::WEIGHT_W-1:0]  full_weight_ff, full_weight_in;
   logic                           csr_write;
   logic                           csr_index;
   logic [LW-1:0]                  eff_len;

   logic               clear_busy;
   logic               fq_valid, fq_ready;
   scsa_pkg::item_type fq_item;
   logic               qb_valid, qb_pop;
   scsa_pkg::item_type qb_item;

   // The register port answers every transfer at once. The register index is
   // taken from the word address, so byte offsets within a word are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      row_length_in  = row_length_ff;
      full_weight_in = full_weight_ff;
      if (csr_write) begin
         case (csr_index)
            scsa_pkg::REG_ROW_LENGTH: begin
               row_length_in = csr_pwdata[scsa_pkg::ROW_LEN_W-1:0];
            end
            scsa_pkg::REG_FULL_WEIGHT: begin
               full_weight_in = csr_pwdata[scsa_pkg::WEIGHT_W-1:0];
            end
            default: begin
               row_length_in = row_length_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         scsa_pkg::REG_ROW_LENGTH: begin
            csr_prdata = scsa_pkg::CSR_DATA_W'(row_length_ff);
         end
         scsa_pkg::REG_FULL_WEIGHT: begin
            csr_prdata = scsa_pkg::CSR_DATA_W'(full_weight_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff  <= scsa_pkg::ROW_LENGTH_RST;
         full_weight_ff <= scsa_pkg::FULL_WEIGHT_RST;
      end else begin
         row_length_ff  <= row_length_in;
         full_weight_ff <= full_weight_in;
      end
   end

   // A programmed row length above the store depth acts as the full depth.
   assign eff_len = (CMP_W'(row_length_ff) > CMP_W'(ROW_WIDTH)) ? LW'(ROW_WIDTH)
                                                              : LW'(row_length_ff);

   scsa_front #(
      .ROW_WIDTH   (ROW_WIDTH),
      .X_FRAC_BITS (X_FRAC_BITS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .eff_len    (eff_len),
      .clear_busy (clear_busy),
      .q_ready    (fq_ready),
      .q_valid    (fq_valid),
      .q_item     (fq_item)
   );

   scsa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_item   (fq_item),
      .out_valid (qb_valid),
      .out_pop   (qb_pop),
      .out_item  (qb_item)
   );

   scsa_back #(
      .ROW_WIDTH   (ROW_WIDTH),
      .X_FRAC_BITS (X_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .eff_len     (eff_len),
      .full_weight (full_weight_ff),
      .q_valid     (qb_valid),
      .q_item      (qb_item),
      .q_pop       (qb_pop),
      .clear_busy  (clear_busy),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== tb/scanline_span_coverage_accumulator_tb.sv =====
// Self-checking testbench for the scanline span coverage accumulator.
`timescale 1ns / 1ps
module scanline_span_coverage_accumulator_tb;

   // Block geometry and run shape.
   localparam int ROW_PIXELS      = scsa_pkg::ROW_WIDTH_DEF;
   localparam int FRAC            = scsa_pkg::X_FRAC_BITS_DEF;
   localparam int X_MAX           = 262143;
   localparam int MAX_GAP         = 18;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 66;
   // A span of the whole row walks all ROW_PIXELS columns in turn, and two more can sit in the
   // front queue, so this many quiet cycles lets any span in flight land.
   localparam int DRAIN_CYCLES    = 3200;
   // Longest legal stretch without a transfer is the drain pause or the clearing pass after
   // reset; the limit is a few times that.
   localparam int WATCHDOG_LIMIT  = 20000;

   // Kinds of rows in the directed table.
   typedef enum logic [1:0] {
      STEP_SPAN,
      STEP_READ,
      STEP_CFG
   } step_kind_type;

   // One directed row. Spans use arg0/arg1 as start/end x, reads use arg0 as the column,
   // register writes use arg0 as the register index and arg1 as the value. When typed is
   // set, want is the pixel value the read must return.
   typedef struct {
      step_kind_type kind;
      int            arg0;
      int            arg1;
      bit            typed;
      int            want;
   } step_type;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   // tdata: start_x[18:0], end_x[37:19], pixel_index[47:38].
   logic [scsa_pkg::REQ_DATA_W-1:0]   req_tdata;
   // tuser: cmd (0 accumulate span, 1 read and clear pixel).
   logic                              req_tuser;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   // tdata: pixel_value[7:0].
   logic [scsa_pkg::PIX_W-1:0]        rsp_tdata;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [scsa_pkg::CSR_ADDR_W-1:0]   csr_paddr;
   logic [scsa_pkg::CSR_DATA_W-1:0]   csr_pwdata;
   logic [scsa_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                              csr_pready;

   // Private copy of the coverage row and of the two registers.
   bit [scsa_pkg::PIX_W-1:0]          cov_model [ROW_PIXELS];
   int                                model_row_len;
   int                                model_weight;

   // Pixel values that reads already transferred in are owed on the result side, oldest first.
   bit [scsa_pkg::PIX_W-1:0]          pixel_expect_q [$];

   int                                mismatch_count;
   int                                quiet_cycles;
   bit                                sender_burst;
   bit                                receiver_burst;

   scanline_span_coverage_accumulator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Adds the partial coverage of one edge column. The covered part of the column is
   // measured in units of 2^-FRAC, scaled by the weight, truncated and saturated.
   function automatic void add_edge_column(input int col, input int s, input int e);
      int lo;
      int hi;
      int covered;
      int sum;
      lo      = col << FRAC;
      hi      = lo + (1 << FRAC);
      covered = (e < lo ? lo : (e > hi ? hi : e)) - (s < lo ? lo : (s > hi ? hi : s));
      sum     = int'(cov_model[col]) + ((covered * model_weight) >> FRAC);
      cov_model[col] = (sum > 255) ? 8'd255 : sum[scsa_pkg::PIX_W-1:0];
   endfunction

   // Accumulates one span into the private row copy.
   function automatic void apply_span(input int s, input int e);
      int len;
      int first_col;
      int end_col;
      int i;
      len = (model_row_len > ROW_PIXELS) ? ROW_PIXELS : model_row_len;
      // Empty row, reversed span, or a span that misses the row entirely: nothing happens.
      if (len == 0 || e < s) return;
      if (s >= (len << FRAC) || e < 0) return;
      first_col = (s < 0) ? 0 : (s >>> FRAC);
      end_col   = (e >>> FRAC) + 1;
      if (end_col > len) end_col = len;
      if (end_col <= first_col) return;
      add_edge_column(first_col, s, e);
      // A span clipped to a single column gets only the one partial update.
      if (end_col - first_col == 1) return;
      // Interior columns take the full weight and wrap rather than saturate.
      for (i = first_col + 1; i + 1 < end_col; i++)
         cov_model[i] = cov_model[i] + model_weight[scsa_pkg::PIX_W-1:0];
      add_edge_column(end_col - 1, s, e);
   endfunction

   // A read returns the pixel and leaves zero behind.
   function automatic bit [scsa_pkg::PIX_W-1:0] take_pixel(input int idx);
      bit [scsa_pkg::PIX_W-1:0] value;
      value = cov_model[idx];
      cov_model[idx] = '0;
      return value;
   endfunction

   // Drives one command and waits for its transfer. Called and returns at a falling edge.
   // tvalid stays high into the next call when that call draws no gap.
   task automatic send_item(input logic cmd, input int sx, input int ex, input int idx,
                            input bit typed, input int want);
      logic signed [scsa_pkg::X_W-1:0] s_field;
      logic signed [scsa_pkg::X_W-1:0] e_field;
      logic [scsa_pkg::IDX_W-1:0]      i_field;
      bit [scsa_pkg::PIX_W-1:0]        pixel;
      int                              gap;
      s_field = sx[scsa_pkg::X_W-1:0];
      e_field = ex[scsa_pkg::X_W-1:0];
      i_field = idx[scsa_pkg::IDX_W-1:0];
      gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 23) == 0) sender_burst = !sender_burst;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {i_field, e_field, s_field};
      do @(posedge clock); while (!req_tready);
      // The transfer happened at this edge; update the prediction in acceptance order.
      if (cmd == scsa_pkg::CMD_READ) begin
         pixel = take_pixel(int'(i_field));
         pixel_expect_q.push_back(typed ? want[scsa_pkg::PIX_W-1:0] : pixel);
      end else begin
         apply_span(int'(s_field), int'(e_field));
      end
      @(negedge clock);
   endtask

   // Stops sending, waits for every owed result, then lets settle more cycles pass so that
   // spans, which produce nothing to wait for, finish in the row walker too.
   task automatic wait_idle(input int settle);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pixel_expect_q.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Setup cycle, then access cycle; the register is written at the edge where the access
   // phase sees pready. An idle gap follows so that back-to-back writes stay apart.
   task automatic write_reg(input logic reg_sel, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_sel == scsa_pkg::REG_ROW_LENGTH) model_row_len = value & 32'h7FF;
      else model_weight = value & 32'hFF;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Result side: draws a stall per result, then holds tready high until a transfer.
   initial begin : result_side
      int gap;
      rsp_tready = 1'b0;
      receiver_burst = 1'b0;
      forever begin
         @(negedge clock);
         gap = receiver_burst ? 0 : $urandom_range(0, MAX_GAP);
         if ($urandom_range(0, 23) == 0) receiver_burst = !receiver_burst;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pixel_expect_q.size() == 0) begin
            report_mismatch("pixel_value with no read pending", rsp_tdata, -1);
         end else if (rsp_tdata !== pixel_expect_q[0]) begin
            report_mismatch("pixel_value", rsp_tdata, pixel_expect_q[0]);
            void'(pixel_expect_q.pop_front());
         end else begin
            void'(pixel_expect_q.pop_front());
         end
      end
   end

   // Watchdog: counts cycles in which no transfer happens on any port.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin : stimulus
      step_type steps [$];
      step_type step;
      int       phase;
      int       n;
      int       pick;
      int       sx;
      int       ex;
      int       idx;
      int       len;
      int       rl;
      int       fw;

      // Every input known from time zero.
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = scsa_pkg::CMD_SPAN;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      quiet_cycles   = 0;
      mismatch_count = 0;
      sender_burst   = 1'b0;
      foreach (cov_model[i]) cov_model[i] = '0;
      model_row_len = int'(scsa_pkg::ROW_LENGTH_RST);
      model_weight  = int'(scsa_pkg::FULL_WEIGHT_RST);

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Reset values first: the row is clear, length 1024, weight 51.
      steps.push_back('{STEP_READ, 0, 0, 1'b1, 0});
      steps.push_back('{STEP_READ, 1023, 0, 1'b1, 0});
      // Columns 4 to 7; it ends exactly on the left edge of column 7, which gets nothing.
      steps.push_back('{STEP_SPAN, 1024, 1792, 1'b0, 0});
      steps.push_back('{STEP_READ, 5, 0, 1'b1, 51});
      steps.push_back('{STEP_READ, 7, 0, 1'b1, 0});
      steps.push_back('{STEP_READ, 4, 0, 1'b1, 51});
      // Both ends inside column 10.
      steps.push_back('{STEP_SPAN, 2624, 2752, 1'b0, 0});
      steps.push_back('{STEP_READ, 10, 0, 1'b0, 0});
      // A reversed span is dropped.
      steps.push_back('{STEP_SPAN, 3000, 2000, 1'b0, 0});
      steps.push_back('{STEP_READ, 11, 0, 1'b1, 0});
      // A span wholly left of zero is dropped.
      steps.push_back('{STEP_SPAN, -5000, -1, 1'b0, 0});
      // Extremes of x, clipped to the whole row.
      steps.push_back('{STEP_SPAN, -262144, X_MAX, 1'b0, 0});
      steps.push_back('{STEP_READ, 0, 0, 1'b0, 0});
      steps.push_back('{STEP_READ, 1023, 0, 1'b0, 0});
      // Heaviest weight: the edge column saturates, interior columns wrap.
      steps.push_back('{STEP_CFG, int'(scsa_pkg::REG_FULL_WEIGHT), 255, 1'b0, 0});
      steps.push_back('{STEP_SPAN, 5120, 5376, 1'b0, 0});
      steps.push_back('{STEP_SPAN, 5120, 5376, 1'b0, 0});
      steps.push_back('{STEP_READ, 20, 0, 1'b1, 255});
      steps.push_back('{STEP_SPAN, 7680, 8448, 1'b0, 0});
      steps.push_back('{STEP_READ, 31, 0, 1'b0, 0});
      // An empty row ignores every span.
      steps.push_back('{STEP_CFG, int'(scsa_pkg::REG_ROW_LENGTH), 0, 1'b0, 0});
      steps.push_back('{STEP_SPAN, 0, 1000, 1'b0, 0});
      steps.push_back('{STEP_READ, 1, 0, 1'b0, 0});
      // A span starting at the end of a short row lies wholly right of it.
      steps.push_back('{STEP_CFG, int'(scsa_pkg::REG_ROW_LENGTH), 4, 1'b0, 0});
      steps.push_back('{STEP_SPAN, 1024, 2000, 1'b0, 0});
      steps.push_back('{STEP_READ, 4, 0, 1'b0, 0});
      // One-column row: both ends clamp into column 0.
      steps.push_back('{STEP_CFG, int'(scsa_pkg::REG_ROW_LENGTH), 1, 1'b0, 0});
      steps.push_back('{STEP_CFG, int'(scsa_pkg::REG_FULL_WEIGHT), 200, 1'b0, 0});
      steps.push_back('{STEP_SPAN, -100, X_MAX, 1'b0, 0});
      steps.push_back('{STEP_READ, 0, 0, 1'b0, 0});

      foreach (steps[k]) begin
         step = steps[k];
         case (step.kind)
            STEP_CFG: begin
               wait_idle(DRAIN_CYCLES);
               write_reg(step.arg0[0], step.arg1);
            end
            STEP_SPAN: begin
               send_item(scsa_pkg::CMD_SPAN, step.arg0, step.arg1, $urandom_range(0, 1023),
                         1'b0, 0);
            end
            default: begin
               send_item(scsa_pkg::CMD_READ, $urandom, $urandom, step.arg0, step.typed,
                         step.want);
            end
         endcase
      end

      // Random part: one register setting per phase, extremes among them.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               rl = 1024;
               fw = 255;
            end
            1: begin
               rl = 1;
               fw = 128;
            end
            2: begin
               rl = 2047;
               fw = $urandom_range(1, 254);
            end
            3: begin
               rl = $urandom_range(2, 1023);
               fw = 0;
            end
            4: begin
               rl = $urandom_range(2, 1023);
               fw = $urandom_range(1, 254);
            end
            default: begin
               rl = 16;
               fw = 200;
            end
         endcase
         wait_idle(DRAIN_CYCLES);
         write_reg(scsa_pkg::REG_ROW_LENGTH, rl);
         write_reg(scsa_pkg::REG_FULL_WEIGHT, fw);
         len = (model_row_len > ROW_PIXELS) ? ROW_PIXELS : model_row_len;

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Halfway through, hold off until every owed result has come back.
            if (n == ITEMS_PER_PHASE / 2) wait_idle(0);
            pick = $urandom_range(0, 99);
            // The last item of a phase is a read, so its result also marks the walker done.
            if (pick < 40 || n == ITEMS_PER_PHASE - 1) begin
               idx = (pick < 4) ? $urandom_range(0, 1023) : $urandom_range(0, len - 1);
               send_item(scsa_pkg::CMD_READ, $urandom, $urandom, idx, 1'b0, 0);
            end else begin
               // Start somewhere from one column left of the row to one column past it.
               sx = (int'($urandom_range(0, len + 1)) - 1) * (1 << FRAC) +
                    int'($urandom_range(0, (1 << FRAC) - 1));
               if (pick < 45) begin
                  // Raw bit patterns: reach every bit of both x fields.
                  sx = $urandom;
                  ex = $urandom;
               end else begin
                  if (pick < 49) ex = sx - int'($urandom_range(1, 1000));
                  else if (pick < 52) ex = sx + int'($urandom_range(0, len << FRAC));
                  else ex = sx + int'($urandom_range(0, 2047));
                  if (ex > X_MAX) ex = X_MAX;
               end
               send_item(scsa_pkg::CMD_SPAN, sx, ex, $urandom_range(0, 1023), 1'b0, 0);
            end
         end
      end

      wait_idle(DRAIN_CYCLES);
      if (mismatch_count == 0 && pixel_expect_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/scsa_pkg.sv
rtl/core/scsa_front.sv
rtl/core/scsa_queue.sv
rtl/core/scsa_back.sv
rtl/core/scanline_span_coverage_accumulator.sv
tb/scanline_span_coverage_accumulator_tb.sv
